[rtl/core/swdh_pkg.sv]
// ----------------------------------------------------------------------------
// SWD host package
// Shared codes and the per-tick result record of the SWD host engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

    // Command codes carried with each base-clock tick
    localparam logic [1:0] MODE_TICK       = 2'd0;
    localparam logic [1:0] MODE_READ       = 2'd1;
    localparam logic [1:0] MODE_WRITE      = 2'd2;
    localparam logic [1:0] MODE_LINE_RESET = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] CFG_BIT_DIVIDER      = 8'd0;
    localparam logic [7:0] CFG_WAIT_RETRY_LIMIT = 8'd1;

    // ACK codes as received, first bit in bit 0
    localparam logic [2:0] ACK_OK   = 3'd1;
    localparam logic [2:0] ACK_WAIT = 3'd2;

    // Completion status
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FAULT     = 2'd1;
    localparam logic [1:0] STATUS_WAIT_OUT  = 2'd2;
    localparam logic [1:0] STATUS_PARITY    = 2'd3;

    // Line reset escape pattern, sent LSB first
    localparam logic [15:0] ESCAPE_PATTERN = 16'hE79E;

    localparam logic [7:0] BIT_DIVIDER_RESET = 8'd31;
    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd16;

    typedef struct packed {
        logic [2:0]  last_ack;
        logic [31:0] read_data;
        logic [1:0]  status;
        logic        done;
        logic        busy;
        logic        swdio_en;
        logic        swdio_out;
        logic        swclk;
    } swdh_result_t;

endpackage

[rtl/core/swd_host_transaction_engine.sv]
// ----------------------------------------------------------------------------
// SWD host transaction engine
// Serial Wire Debug host bit engine driven by one base-clock tick per item.
// ----------------------------------------------------------------------------
// Each slave-side transaction is one base-clock tick. Its tuser carries the
// command (tick only, read, write or line reset); a command is only taken
// while the engine is idle and is ignored otherwise. tdata carries the
// request header, the write word and the sampled SWDIO level.
// Each tick yields exactly one master-side transaction with the SWCLK,
// SWDIO and output-enable levels, busy and done flags, the completion
// status, the last read word and the last ACK.
// A tick is captured in an input register, worked out in one pass through
// the bit engine and written to the result register, from which it is offered.
// While the receiver takes results, one tick is taken every cycle;
// the input register is refilled in the same cycle the result register is
// loaded, so ticks flow back to back.
// If the receiver stalls, the result register holds and the input register
// keeps its tick; tready then drops until the result is taken.
// The configuration channel writes the bit divider (index 0) and the WAIT
// retry limit (index 1); it is always ready. The user must write it only
// while idle; the block does not enforce this. Reset (rst_n low) empties
// both registers and returns the engine to idle, divider 31, retry limit 16.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine
    import swdh_pkg::*;
#(
    parameter int LEADER_BITS       = 8,
    parameter int RESET_HIGH_CLOCKS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave side: one base-clock tick per transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // header[7:0], write_data[39:8], swdio_in[40], zero[47:41]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // Master side: one result per tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // swclk[0], swdio_out[1], swdio_en[2], busy_res[3],
                                   // done_res[4], status[6:5], read_data[38:7],
                                   // last_ack[41:39], zero[47:42]
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic         in_valid_reg;
    logic [1:0]   in_mode_reg;
    logic [40:0]  in_data_reg;
    logic         out_valid_reg;
    swdh_result_t out_result_reg;
    swdh_result_t step_result;
    logic         advance;
    logic [7:0]   bit_divider_reg;
    logic [7:0]   retry_limit_reg;

    // The engine steps when a tick is held and the result register can take it.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_divider_reg <= BIT_DIVIDER_RESET;
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BIT_DIVIDER:      bit_divider_reg <= cfg_data;
                CFG_WAIT_RETRY_LIMIT: retry_limit_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Input register: valid flag under reset, payload plain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_data_reg <= s_tdata[40:0];
        end
    end

    swdh_engine #(
        .LEADER_BITS       (LEADER_BITS),
        .RESET_HIGH_CLOCKS (RESET_HIGH_CLOCKS)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .mode             (in_mode_reg),
        .header           (in_data_reg[7:0]),
        .write_data       (in_data_reg[39:8]),
        .swdio_in         (in_data_reg[40]),
        .bit_divider      (bit_divider_reg),
        .wait_retry_limit (retry_limit_reg),
        .result           (step_result)
    );

    // Result register: loaded whenever the engine steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_result_reg.last_ack,
                       out_result_reg.read_data,
                       out_result_reg.status,
                       out_result_reg.done,
                       out_result_reg.busy,
                       out_result_reg.swdio_en,
                       out_result_reg.swdio_out,
                       out_result_reg.swclk};

    // A finishing tick always leaves the engine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.done |-> !out_result_reg.busy)
        else $error("done reported while engine still busy");

    // An idle tick shows idle pin levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.busy && !out_result_reg.done |->
        !out_result_reg.swclk && out_result_reg.swdio_out && out_result_reg.swdio_en)
        else $error("pins not at idle levels on an idle tick");

    // A held tick that cannot step is kept for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("stalled tick lost from input register");

endmodule

[rtl/core/swdh_engine.sv]
// ----------------------------------------------------------------------------
// SWD host bit engine
// Holds the protocol state and works out one base-clock tick per step.
// ----------------------------------------------------------------------------
module swdh_engine
    import swdh_pkg::*;
#(
    parameter int LEADER_BITS       = 8,
    parameter int RESET_HIGH_CLOCKS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         mode,
    input  logic [7:0]         header,
    input  logic [31:0]        write_data,
    input  logic               swdio_in,
    input  logic [7:0]         bit_divider,
    input  logic [7:0]         wait_retry_limit,
    output swdh_result_t       result
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_RST_A   = 3'd1;
    localparam logic [2:0] PH_RST_PAT = 3'd2;
    localparam logic [2:0] PH_RST_B   = 3'd3;
    localparam logic [2:0] PH_HDR     = 3'd4;
    localparam logic [2:0] PH_RDATA   = 3'd5;
    localparam logic [2:0] PH_WDATA   = 3'd6;

    localparam logic [6:0] RST_LEN   = 7'(RESET_HIGH_CLOCKS);
    localparam logic [6:0] PAT_LEN   = 7'd16;
    localparam logic [6:0] HDR_LEN   = 7'(LEADER_BITS + 12);
    localparam logic [6:0] DATA_LEN  = 7'd34;
    localparam logic [6:0] TURN_BIT  = 7'(LEADER_BITS + 8);
    localparam int         ACK_LSB   = LEADER_BITS + 9;

    logic [2:0]  phase_reg,        phase_next;
    logic [6:0]  bit_count_reg,    bit_count_next;
    logic [7:0]  tick_count_reg,   tick_count_next;
    logic [33:0] out_shift_reg,    out_shift_next;
    logic [33:0] in_shift_reg,     in_shift_next;
    logic [7:0]  retries_reg,      retries_next;
    logic        held_read_reg,    held_read_next;
    logic [7:0]  held_header_reg,  held_header_next;
    logic [31:0] held_wdata_reg,   held_wdata_next;
    logic [1:0]  status_reg,       status_next;
    logic [31:0] read_data_reg,    read_data_next;
    logic [2:0]  last_ack_reg,     last_ack_next;

    logic [33:0] in_sampled;
    logic [6:0]  bit_inc;
    logic [6:0]  phase_len;
    logic [2:0]  ack;
    logic        cmd_done;

    // Leader zeros, then the header byte, then idle-high bits.
    function automatic logic [33:0] header_frame(input logic [7:0] hdr);
        return (~34'h0 << (LEADER_BITS + 8)) | (34'(hdr) << LEADER_BITS);
    endfunction

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        tick_count_next  = tick_count_reg;
        out_shift_next   = out_shift_reg;
        in_shift_next    = in_shift_reg;
        retries_next     = retries_reg;
        held_read_next   = held_read_reg;
        held_header_next = held_header_reg;
        held_wdata_next  = held_wdata_reg;
        status_next      = status_reg;
        read_data_next   = read_data_reg;
        last_ack_next    = last_ack_reg;
        in_sampled       = in_shift_reg;
        bit_inc          = bit_count_reg + 7'd1;
        ack              = in_shift_reg[ACK_LSB +: 3];
        phase_len        = DATA_LEN;
        cmd_done         = 1'b0;
        result.swclk     = 1'b0;
        result.swdio_out = 1'b1;
        result.swdio_en  = 1'b1;

        if (phase_reg == PH_IDLE || phase_reg > PH_WDATA)
        begin
            phase_next = PH_IDLE;
            if (mode == MODE_LINE_RESET)
            begin
                phase_next      = PH_RST_A;
                bit_count_next  = '0;
                tick_count_next = '0;
                out_shift_next  = '1;
                in_shift_next   = '0;
            end
            else if (mode != MODE_TICK)
            begin
                held_read_next   = (mode == MODE_READ);
                held_header_next = header;
                held_wdata_next  = write_data;
                retries_next     = wait_retry_limit;
                phase_next       = PH_HDR;
                bit_count_next   = '0;
                tick_count_next  = '0;
                out_shift_next   = header_frame(header);
                in_shift_next    = '0;
            end
        end
        else
        begin
            // The target drives SWDIO from the turnaround bit through the ACK, and through the data on a read.
            result.swdio_en  = !(phase_reg == PH_RDATA ||
                                 (phase_reg == PH_HDR && bit_count_reg >= TURN_BIT));
            result.swdio_out = result.swdio_en ? out_shift_reg[0] : 1'b1;
            result.swclk     = (tick_count_reg > (bit_divider >> 1));

            if (tick_count_reg < bit_divider)
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end
            else
            begin
                tick_count_next = '0;
                if (bit_count_reg < DATA_LEN)
                begin
                    in_sampled = in_shift_reg | (34'(swdio_in) << bit_count_reg[5:0]);
                end
                in_shift_next  = in_sampled;
                out_shift_next = {1'b1, out_shift_reg[33:1]};
                bit_count_next = bit_inc;
                ack            = in_sampled[ACK_LSB +: 3];

                unique case (phase_reg)
                    PH_RST_A, PH_RST_B: phase_len = RST_LEN;
                    PH_RST_PAT:         phase_len = PAT_LEN;
                    PH_HDR:             phase_len = HDR_LEN;
                    default:            phase_len = DATA_LEN;
                endcase

                if (bit_inc >= phase_len)
                begin
                    unique case (phase_reg)
                        PH_RST_A:
                        begin
                            phase_next      = PH_RST_PAT;
                            bit_count_next  = '0;
                            out_shift_next  = {18'h3FFFF, ESCAPE_PATTERN};
                            in_shift_next   = '0;
                        end
                        PH_RST_PAT:
                        begin
                            phase_next      = PH_RST_B;
                            bit_count_next  = '0;
                            out_shift_next  = '1;
                            in_shift_next   = '0;
                        end
                        PH_HDR:
                        begin
                            last_ack_next = ack;
                            if (ack == ACK_OK)
                            begin
                                bit_count_next = '0;
                                in_shift_next  = '0;
                                if (held_read_reg)
                                begin
                                    phase_next     = PH_RDATA;
                                    out_shift_next = '1;
                                end
                                else
                                begin
                                    phase_next     = PH_WDATA;
                                    out_shift_next = {^held_wdata_reg, held_wdata_reg, 1'b1};
                                end
                            end
                            else if (ack == ACK_WAIT && retries_reg != 8'd0)
                            begin
                                retries_next   = retries_reg - 8'd1;
                                phase_next     = PH_HDR;
                                bit_count_next = '0;
                                out_shift_next = header_frame(held_header_reg);
                                in_shift_next  = '0;
                            end
                            else
                            begin
                                status_next = (ack == ACK_WAIT) ? STATUS_WAIT_OUT
                                                                : STATUS_FAULT;
                                cmd_done    = 1'b1;
                            end
                        end
                        PH_RDATA:
                        begin
                            if ((^in_sampled[31:0]) != in_sampled[32])
                            begin
                                status_next = STATUS_PARITY;
                            end
                            else
                            begin
                                read_data_next = in_sampled[31:0];
                                status_next    = STATUS_OK;
                            end
                            cmd_done = 1'b1;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                            cmd_done    = 1'b1;
                        end
                    endcase
                end

                if (cmd_done)
                begin
                    phase_next     = PH_IDLE;
                    bit_count_next = '0;
                    out_shift_next = '1;
                end
            end
        end

        result.busy      = (phase_next != PH_IDLE);
        result.done      = cmd_done;
        result.status    = status_next;
        result.read_data = read_data_next;
        result.last_ack  = last_ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            tick_count_reg  <= '0;
            out_shift_reg   <= '1;
            in_shift_reg    <= '0;
            retries_reg     <= '0;
            held_read_reg   <= 1'b0;
            held_header_reg <= '0;
            held_wdata_reg  <= '0;
            status_reg      <= STATUS_OK;
            read_data_reg   <= '0;
            last_ack_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            tick_count_reg  <= tick_count_next;
            out_shift_reg   <= out_shift_next;
            in_shift_reg    <= in_shift_next;
            retries_reg     <= retries_next;
            held_read_reg   <= held_read_next;
            held_header_reg <= held_header_next;
            held_wdata_reg  <= held_wdata_next;
            status_reg      <= status_next;
            read_data_reg   <= read_data_next;
            last_ack_reg    <= last_ack_next;
        end
    end

endmodule
